### design/ittl_pkg.sv
// Shared types and constants for the IP TTL decrement and encapsulation block.
`timescale 1ns / 1ps
`default_nettype none

package ittl_pkg;

    localparam int HDR_DEPTH = 60;
    localparam int HDR_AW    = $clog2(HDR_DEPTH);
    localparam int HLEN_W    = $clog2(HDR_DEPTH + 1);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [16:0] MAX_OUT_RST = 17'h10000;

    localparam logic [3:0] VER_V4 = 4'd4;
    localparam logic [3:0] VER_V6 = 4'd6;

    localparam int V4_MIN_HLEN = 20;
    localparam int V6_HLEN     = 40;

    localparam logic [15:0] IDX_V4_TLEN_HI = 16'd2;
    localparam logic [15:0] IDX_V4_TLEN_LO = 16'd3;
    localparam logic [15:0] IDX_V6_PLEN_HI = 16'd4;
    localparam logic [15:0] IDX_V6_PLEN_LO = 16'd5;
    localparam logic [15:0] IDX_V6_HOP     = 16'd7;
    localparam logic [15:0] IDX_V4_TTL     = 16'd8;
    localparam logic [15:0] IDX_V4_CSUM_HI = 16'd10;
    localparam logic [15:0] IDX_V4_CSUM_LO = 16'd11;

    localparam logic [7:0] CTX_BYTE = 8'h00;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_SHORT = 3'd2,
        ST_TTL   = 3'd3,
        ST_VER   = 3'd4,
        ST_OVF   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_COLLECT,
        PH_PASS,
        PH_DROP
    } phase_t;

    typedef enum logic [1:0] {
        CMD_STATUS,
        CMD_BYTE,
        CMD_HEADER
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_HDR
    } back_state_t;

    // One queued job for the back end
    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        byte_val;
        status_t           status;
        logic              last;
        logic [15:0]       csum;
        logic [HLEN_W-1:0] hlen;
        logic              v4;
    } cmd_t;

    // Header buffer write port
    typedef struct packed {
        logic              en;
        logic [HDR_AW-1:0] addr;
        logic [7:0]        data;
    } hdr_wr_t;

endpackage

`default_nettype wire

### design/ittl_queue.sv
// Small command FIFO between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module ittl_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ittl_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output ittl_pkg::cmd_t     pop_data,
    output logic               empty
);
    import ittl_pkg::*;

    cmd_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;

    assign full     = (count_reg == Q_CW'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + Q_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

### design/ittl_front.sv
// Front end: takes packet beats, checks the header, fills the header buffer, queues jobs.
`timescale 1ns / 1ps
`default_nettype none

module ittl_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      data_byte,
    input  wire logic [15:0]     pkt_len,
    input  wire logic            cfg_valid,
    input  wire logic [16:0]     cfg_data,
    input  wire logic            q_full,
    output logic                 q_push,
    output ittl_pkg::cmd_t       q_cmd,
    output ittl_pkg::hdr_wr_t    hdr_wr,
    input  wire logic            hdr_done
);
    import ittl_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [15:0]       byte_cnt_reg, byte_cnt_next;
    logic [15:0]       pkt_len_reg, pkt_len_next;
    logic [HLEN_W-1:0] hdr_len_reg, hdr_len_next;
    logic              hdr_busy_reg, hdr_busy_next;
    logic [16:0]       max_out_len_reg, max_out_len_next;

    logic              v6_reg, v6_next;
    logic              ovf_reg, ovf_next;
    logic              short_reg, short_next;
    logic              ttl_ok_reg, ttl_ok_next;
    logic [7:0]        hi_reg, hi_next;
    logic [7:0]        lhi_reg, lhi_next;
    logic [15:0]       csum_reg, csum_next;

    logic              accept;

    assign in_ready = !q_full && !(phase_reg == PH_COLLECT && hdr_busy_reg);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_t      ph;
        logic [15:0] plen;
        logic [15:0] cnt;
        logic        first;
        logic        done;
        logic        v6;
        logic [5:0]  hl;
        logic [7:0]  wdata;
        logic [16:0] sum17;
        logic [15:0] csum_v;
        logic [16:0] pl_sum;
        status_t     err;
        status_t     fin;

        phase_next       = phase_reg;
        byte_cnt_next    = byte_cnt_reg;
        pkt_len_next     = pkt_len_reg;
        hdr_len_next     = hdr_len_reg;
        hdr_busy_next    = hdr_busy_reg;
        max_out_len_next = max_out_len_reg;
        v6_next          = v6_reg;
        ovf_next         = ovf_reg;
        short_next       = short_reg;
        ttl_ok_next      = ttl_ok_reg;
        hi_next          = hi_reg;
        lhi_next         = lhi_reg;
        csum_next        = csum_reg;
        q_push           = 1'b0;
        q_cmd            = '0;
        hdr_wr           = '0;

        ph     = phase_reg;
        plen   = pkt_len_reg;
        cnt    = byte_cnt_reg;
        first  = (phase_reg == PH_COLLECT) && (byte_cnt_reg == '0);
        done   = 1'b0;
        v6     = v6_reg;
        hl     = {data_byte[3:0], 2'b00};
        wdata  = data_byte;
        sum17  = '0;
        csum_v = csum_reg;
        pl_sum = '0;
        err    = ST_OK;
        fin    = ST_OK;

        if (cfg_valid)
        begin
            max_out_len_next = cfg_data;
        end

        if (hdr_done)
        begin
            hdr_busy_next = 1'b0;
        end

        if (accept)
        begin
            if (pkt_len == '0)
            begin
                byte_cnt_next  = '0;
                phase_next     = PH_COLLECT;
                q_push         = 1'b1;
                q_cmd.kind     = CMD_STATUS;
                q_cmd.status   = ST_EMPTY;
                q_cmd.last     = 1'b1;
            end
            else
            begin
                if (first)
                begin
                    plen         = pkt_len;
                    pkt_len_next = pkt_len;
                    v6           = (data_byte[7:4] == VER_V6);
                    v6_next      = v6;
                    ovf_next     = ({1'b0, pkt_len} + 17'd1) > max_out_len_reg;
                    short_next   = 1'b0;
                    csum_v       = '0;
                    if (data_byte[7:4] == VER_V4)
                    begin
                        if (pkt_len < 16'(V4_MIN_HLEN) || hl < 6'(V4_MIN_HLEN)
                            || 16'(hl) > pkt_len || int'(hl) > HDR_DEPTH)
                        begin
                            err = ST_SHORT;
                        end
                        else
                        begin
                            hdr_len_next = HLEN_W'(hl);
                        end
                    end
                    else if (v6)
                    begin
                        if (pkt_len < 16'(V6_HLEN) || V6_HLEN > HDR_DEPTH)
                        begin
                            err = ST_SHORT;
                        end
                        else
                        begin
                            hdr_len_next = HLEN_W'(V6_HLEN);
                        end
                    end
                    else
                    begin
                        err = ST_VER;
                    end
                    if (err != ST_OK)
                    begin
                        q_push       = 1'b1;
                        q_cmd.kind   = CMD_STATUS;
                        q_cmd.status = err;
                        q_cmd.last   = 1'b1;
                        ph           = PH_DROP;
                    end
                end

                done = ({1'b0, byte_cnt_reg} + 17'd1) == {1'b0, plen};

                if (ph == PH_COLLECT)
                begin
                    // TTL / hop limit is stored already decremented
                    if ((!v6 && byte_cnt_reg == IDX_V4_TTL) || (v6 && byte_cnt_reg == IDX_V6_HOP))
                    begin
                        ttl_ok_next = data_byte > 8'd1;
                        wdata       = data_byte - 8'd1;
                    end
                    if (int'(byte_cnt_reg) < HDR_DEPTH)
                    begin
                        hdr_wr.en   = 1'b1;
                        hdr_wr.addr = byte_cnt_reg[HDR_AW-1:0];
                        hdr_wr.data = wdata;
                    end
                    if ((!v6 && byte_cnt_reg == IDX_V4_TLEN_HI)
                        || (v6 && byte_cnt_reg == IDX_V6_PLEN_HI))
                    begin
                        lhi_next = data_byte;
                    end
                    if (!v6 && byte_cnt_reg == IDX_V4_TLEN_LO)
                    begin
                        short_next = {lhi_reg, data_byte} > pkt_len_reg;
                    end
                    if (v6 && byte_cnt_reg == IDX_V6_PLEN_LO)
                    begin
                        pl_sum     = {1'b0, lhi_reg, data_byte} + 17'(V6_HLEN);
                        short_next = pl_sum > {1'b0, pkt_len_reg};
                    end
                    // running ones'-complement sum, checksum word skipped
                    if (!byte_cnt_reg[0])
                    begin
                        hi_next = wdata;
                    end
                    else if (!v6 && byte_cnt_reg != IDX_V4_CSUM_LO)
                    begin
                        sum17  = {1'b0, csum_reg} + {1'b0, hi_reg, data_byte};
                        csum_v = sum17[15:0] + 16'(sum17[16]);
                    end

                    if (({1'b0, byte_cnt_reg} + 17'd1) == 17'(hdr_len_next))
                    begin
                        if (short_next)
                        begin
                            fin = ST_SHORT;
                        end
                        else if (!ttl_ok_next)
                        begin
                            fin = ST_TTL;
                        end
                        else if (ovf_reg)
                        begin
                            fin = ST_OVF;
                        end
                        q_push = 1'b1;
                        if (fin != ST_OK)
                        begin
                            q_cmd.kind   = CMD_STATUS;
                            q_cmd.status = fin;
                            q_cmd.last   = 1'b1;
                            ph           = PH_DROP;
                        end
                        else
                        begin
                            q_cmd.kind    = CMD_HEADER;
                            q_cmd.status  = ST_OK;
                            q_cmd.last    = done;
                            q_cmd.csum    = ~csum_v;
                            q_cmd.hlen    = hdr_len_next;
                            q_cmd.v4      = !v6;
                            hdr_busy_next = 1'b1;
                            ph            = PH_PASS;
                        end
                    end
                end
                else if (ph == PH_PASS)
                begin
                    q_push         = 1'b1;
                    q_cmd.kind     = CMD_BYTE;
                    q_cmd.byte_val = data_byte;
                    q_cmd.status   = ST_OK;
                    q_cmd.last     = done;
                end

                csum_next = csum_v;
                cnt       = byte_cnt_reg + 16'd1;
                if (done || cnt >= plen)
                begin
                    cnt = '0;
                    ph  = PH_COLLECT;
                end
                byte_cnt_next = cnt;
                phase_next    = ph;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_COLLECT;
            byte_cnt_reg    <= '0;
            pkt_len_reg     <= '0;
            hdr_len_reg     <= '0;
            hdr_busy_reg    <= 1'b0;
            max_out_len_reg <= MAX_OUT_RST;
        end
        else
        begin
            phase_reg       <= phase_next;
            byte_cnt_reg    <= byte_cnt_next;
            pkt_len_reg     <= pkt_len_next;
            hdr_len_reg     <= hdr_len_next;
            hdr_busy_reg    <= hdr_busy_next;
            max_out_len_reg <= max_out_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v6_reg     <= v6_next;
        ovf_reg    <= ovf_next;
        short_reg  <= short_next;
        ttl_ok_reg <= ttl_ok_next;
        hi_reg     <= hi_next;
        lhi_reg    <= lhi_next;
        csum_reg   <= csum_next;
    end

    a_no_wr_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_wr.en |-> !hdr_busy_reg)
        else $error("header buffer written while previous header is being sent");
    a_hdr_len_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_cmd.kind == CMD_HEADER) |->
            (int'(q_cmd.hlen) >= V4_MIN_HLEN && int'(q_cmd.hlen) <= HDR_DEPTH))
        else $error("header job with bad length");

endmodule

`default_nettype wire

### design/ittl_back.sv
// Back end: header buffer, header replay with checksum insert, output register.
`timescale 1ns / 1ps
`default_nettype none

module ittl_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire ittl_pkg::cmd_t    q_data,
    output logic                   q_pop,
    input  wire ittl_pkg::hdr_wr_t hdr_wr,
    output logic                   hdr_done,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   has_byte,
    output logic [2:0]             status,
    output logic                   last
);
    import ittl_pkg::*;

    logic [7:0]        hdr_mem [HDR_DEPTH];
    logic [7:0]        rd_data_reg;

    back_state_t       state_reg, state_next;
    cmd_t              job_reg, job_next;
    logic [HDR_AW-1:0] idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              has_byte_reg, has_byte_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;

    logic              can_load;
    logic              at_end;
    logic              rd_en;
    logic [HDR_AW-1:0] rd_addr;
    logic [7:0]        hdr_byte;

    assign can_load = !out_valid_reg || out_ready;
    assign at_end   = (HLEN_W'(idx_reg) + HLEN_W'(1)) == job_reg.hlen;

    always_comb
    begin
        hdr_byte = rd_data_reg;
        if (job_reg.v4 && idx_reg == HDR_AW'(IDX_V4_CSUM_HI))
        begin
            hdr_byte = job_reg.csum[15:8];
        end
        else if (job_reg.v4 && idx_reg == HDR_AW'(IDX_V4_CSUM_LO))
        begin
            hdr_byte = job_reg.csum[7:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && can_load && q_data.kind == CMD_HEADER)
                begin
                    state_next = BK_HDR;
                end
            end
            BK_HDR:
            begin
                if (can_load && at_end)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        q_pop          = 1'b0;
        hdr_done       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        job_next       = job_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        has_byte_next  = has_byte_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && can_load)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    case (q_data.kind)
                        CMD_BYTE:
                        begin
                            out_byte_next = q_data.byte_val;
                            has_byte_next = 1'b1;
                            status_next   = ST_OK;
                            last_next     = q_data.last;
                        end
                        CMD_HEADER:
                        begin
                            out_byte_next = CTX_BYTE;
                            has_byte_next = 1'b1;
                            status_next   = ST_OK;
                            last_next     = 1'b0;
                            job_next      = q_data;
                            idx_next      = '0;
                            rd_en         = 1'b1;
                            rd_addr       = '0;
                        end
                        default:
                        begin
                            out_byte_next = '0;
                            has_byte_next = 1'b0;
                            status_next   = q_data.status;
                            last_next     = 1'b1;
                        end
                    endcase
                end
            end
            BK_HDR:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = hdr_byte;
                    has_byte_next  = 1'b1;
                    status_next    = ST_OK;
                    last_next      = at_end && job_reg.last;
                    if (at_end)
                    begin
                        hdr_done = 1'b1;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + HDR_AW'(1);
                        idx_next = idx_reg + HDR_AW'(1);
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hdr_wr.en)
        begin
            hdr_mem[hdr_wr.addr] <= hdr_wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= hdr_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        has_byte_reg <= has_byte_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign has_byte  = has_byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    a_idx_in_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_HDR) |-> (HLEN_W'(idx_reg) < job_reg.hlen))
        else $error("header replay index past header length");

endmodule

`default_nettype wire

### design/ip_ttl_decrement_encapsulate.sv
// Top level: IP TTL / hop-limit decrement with context-byte encapsulation.
//
// Takes one packet byte per beat (pkt_len repeated on each beat) and returns
// a context byte 0x00, the header with TTL or hop limit decremented (IPv4
// checksum recomputed over the whole IHL*4 header), then the payload; on a
// failed check one status beat replaces the packet. Header bytes are taken
// at one per cycle into a 60-byte buffer while the queue is not full and no
// earlier header is still being replayed; once the header is complete the
// back end replays it through the buffer's single read port while up to 4
// queued payload beats are absorbed. Payload then runs at one byte per cycle
// while the queue is not full and the output is not stalled. The next
// packet's header is not taken until the replay has finished.
// cfg_ready is always high; max_out_len should only be written while idle.
`timescale 1ns / 1ps
`default_nettype none

module ip_ttl_decrement_encapsulate (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] pkt_len,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             has_byte,
    output logic [2:0]       status,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [16:0] cfg_data
);
    import ittl_pkg::*;

    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    cmd_t    q_in;
    cmd_t    q_out;
    hdr_wr_t hdr_wr;
    logic    hdr_done;

    assign cfg_ready = 1'b1;

    ittl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .pkt_len   (pkt_len),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_in),
        .hdr_wr    (hdr_wr),
        .hdr_done  (hdr_done)
    );

    ittl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    ittl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .hdr_wr    (hdr_wr),
        .hdr_done  (hdr_done),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .status    (status),
        .last      (last)
    );

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the IP TTL decrement and encapsulation block.
`timescale 1ns / 1ps

module tb_top;
    import ittl_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int N_PROBES    = 22;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        status_t    st;
        logic       fin;
    } dgram_beat_t;

    typedef struct packed {
        logic [7:0]  d;
        logic [15:0] len;
        logic        typed;
        status_t     st;
    } probe_row_t;

    localparam probe_row_t PROBES [N_PROBES] = '{
        '{8'hA5, 16'd0,     1'b1, ST_EMPTY},
        '{8'hFF, 16'hFFFF,  1'b1, ST_VER},
        '{8'h00, 16'd0,     1'b1, ST_EMPTY},
        '{8'h00, 16'd1,     1'b1, ST_VER},
        '{8'h45, 16'd19,    1'b1, ST_SHORT},
        '{8'h3C, 16'd0,     1'b1, ST_EMPTY},
        '{8'h44, 16'd100,   1'b1, ST_SHORT},
        '{8'h11, 16'd0,     1'b1, ST_EMPTY},
        '{8'h4F, 16'd59,    1'b1, ST_SHORT},
        '{8'h22, 16'd0,     1'b1, ST_EMPTY},
        '{8'h60, 16'd39,    1'b1, ST_SHORT},
        '{8'h00, 16'd0,     1'b1, ST_EMPTY},
        '{8'h50, 16'd2,     1'b1, ST_VER},
        '{8'h45, 16'd7,     1'b0, ST_OK},
        '{8'h7F, 16'd1,     1'b1, ST_VER},
        '{8'h6F, 16'd40,    1'b0, ST_OK},
        '{8'hFF, 16'd40,    1'b0, ST_OK},
        '{8'h00, 16'd0,     1'b1, ST_EMPTY},
        '{8'h4F, 16'hFFFF,  1'b0, ST_OK},
        '{8'h80, 16'h8000,  1'b0, ST_OK},
        '{8'h01, 16'd0,     1'b1, ST_EMPTY},
        '{8'h41, 16'd0,     1'b1, ST_EMPTY}
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic [15:0] pkt_len   = 16'h0000;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic [2:0]  status;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data  = 17'h00000;

    // typed expectation riding along with the current input beat
    logic        beat_typed = 1'b0;
    status_t     beat_st    = ST_OK;

    // predictor state
    logic [7:0]  hdr_mem [HDR_DEPTH];
    logic [15:0] model_count;
    logic [15:0] model_plen;
    int          model_hlen;
    phase_t      model_phase;
    logic [16:0] model_cap;

    dgram_beat_t step_beats [$];
    dgram_beat_t due_beats [$];

    int fail_count = 0;
    int sent_items = 0;
    int tx_calm    = 0;
    int cycles     = 0;
    bit hold_req   = 1'b0;

    ip_ttl_decrement_encapsulate u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .pkt_len   (pkt_len),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .status    (status),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    function automatic dgram_beat_t status_beat(input status_t s);
        return '{data: 8'h00, has: 1'b0, st: s, fin: 1'b1};
    endfunction

    function automatic logic [15:0] header_csum(input int hl);
        logic [31:0] sum;
        sum = 32'd0;
        for (int i = 0; i + 1 < hl; i += 2)
        begin
            if (i != int'(IDX_V4_CSUM_HI))
                sum = sum + {16'h0000, hdr_mem[i], hdr_mem[i + 1]};
        end
        while (sum[31:16] != 16'h0000)
            sum = {16'h0000, sum[15:0]} + {16'h0000, sum[31:16]};
        return ~sum[15:0];
    endfunction

    // Late header checks; decrements TTL / hop limit and patches the IPv4 checksum on success.
    function automatic status_t check_and_edit_header();
        int          tl;
        int          pl;
        logic [15:0] ck;
        if (hdr_mem[0][7:4] == VER_V4)
        begin
            tl = {hdr_mem[IDX_V4_TLEN_HI], hdr_mem[IDX_V4_TLEN_LO]};
            if (tl > int'(model_plen))
                return ST_SHORT;
            if (hdr_mem[IDX_V4_TTL] <= 8'd1)
                return ST_TTL;
            if (1 + int'(model_plen) > int'(model_cap))
                return ST_OVF;
            hdr_mem[IDX_V4_TTL] = hdr_mem[IDX_V4_TTL] - 8'd1;
            ck = header_csum(model_hlen);
            hdr_mem[IDX_V4_CSUM_HI] = ck[15:8];
            hdr_mem[IDX_V4_CSUM_LO] = ck[7:0];
        end
        else
        begin
            pl = {hdr_mem[IDX_V6_PLEN_HI], hdr_mem[IDX_V6_PLEN_LO]};
            if (pl + V6_HLEN > int'(model_plen))
                return ST_SHORT;
            if (hdr_mem[IDX_V6_HOP] <= 8'd1)
                return ST_TTL;
            if (1 + int'(model_plen) > int'(model_cap))
                return ST_OVF;
            hdr_mem[IDX_V6_HOP] = hdr_mem[IDX_V6_HOP] - 8'd1;
        end
        return ST_OK;
    endfunction

    // Datagram beats caused by one accepted packet byte.
    function automatic void forward_byte(input logic [7:0] d, input logic [15:0] len);
        logic [3:0] ver;
        status_t    err;
        status_t    st;
        int         hl;
        logic       done;
        step_beats.delete();
        if (len == 16'd0)
        begin
            model_count = 16'd0;
            model_phase = PH_COLLECT;
            step_beats.push_back(status_beat(ST_EMPTY));
            return;
        end
        if (model_phase == PH_COLLECT && model_count == 16'd0)
        begin
            ver = d[7:4];
            err = ST_OK;
            model_plen = len;
            if (ver == VER_V4)
            begin
                hl = int'(d[3:0]) * 4;
                if (int'(len) < V4_MIN_HLEN || hl < V4_MIN_HLEN || hl > int'(len)
                    || hl > HDR_DEPTH)
                    err = ST_SHORT;
                else
                    model_hlen = hl;
            end
            else if (ver == VER_V6)
            begin
                if (int'(len) < V6_HLEN || V6_HLEN > HDR_DEPTH)
                    err = ST_SHORT;
                else
                    model_hlen = V6_HLEN;
            end
            else
                err = ST_VER;
            if (err != ST_OK)
            begin
                step_beats.push_back(status_beat(err));
                model_phase = PH_DROP;
            end
        end
        done = (int'(model_count) + 1 == int'(model_plen));
        if (model_phase == PH_COLLECT)
        begin
            hdr_mem[int'(model_count)] = d;
            if (int'(model_count) + 1 == model_hlen)
            begin
                st = check_and_edit_header();
                if (st != ST_OK)
                begin
                    step_beats.push_back(status_beat(st));
                    model_phase = PH_DROP;
                end
                else
                begin
                    step_beats.push_back('{data: CTX_BYTE, has: 1'b1, st: ST_OK, fin: 1'b0});
                    for (int i = 0; i < model_hlen; i++)
                        step_beats.push_back('{data: hdr_mem[i], has: 1'b1, st: ST_OK,
                                               fin: (i + 1 == model_hlen) ? done : 1'b0});
                    model_phase = PH_PASS;
                end
            end
        end
        else if (model_phase == PH_PASS)
            step_beats.push_back('{data: d, has: 1'b1, st: ST_OK, fin: done});
        model_count = model_count + 16'd1;
        if (done || model_count >= model_plen)
        begin
            model_count = 16'd0;
            model_phase = PH_COLLECT;
        end
    endfunction

    function automatic void flag(input string what, input dgram_beat_t want);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: got %02h/%0d/%0d/%0d want %02h/%0d/%0d/%0d (byte/has/status/last)",
                     what, out_byte, has_byte, status, last,
                     want.data, want.has, want.st, want.fin);
    endfunction

    function automatic void check_beat();
        dgram_beat_t want;
        if (due_beats.size() == 0)
            flag("unexpected beat", '0);
        else
        begin
            want = due_beats.pop_front();
            if (out_byte !== want.data || has_byte !== want.has
                || status !== want.st || last !== want.fin)
                flag("mismatch", want);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                model_cap = cfg_data;
            if (in_valid && in_ready)
            begin
                sent_items++;
                forward_byte(data_byte, pkt_len);
                if (beat_typed)
                    due_beats.push_back(status_beat(beat_st));
                else
                    foreach (step_beats[i])
                        due_beats.push_back(step_beats[i]);
            end
            if (out_valid && out_ready)
                check_beat();
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    task automatic send_beat(input logic [7:0] d, input logic [15:0] len, input logic typed,
                             input status_t st);
        int gap;
        @(negedge clk);
        in_valid   <= 1'b1;
        data_byte  <= d;
        pkt_len    <= len;
        beat_typed <= typed;
        beat_st    <= st;
        do
            @(posedge clk);
        while (!in_ready);
        if (tx_calm > 0)
        begin
            gap = 0;
            tx_calm--;
        end
        else if ($urandom_range(0, 199) == 0)
        begin
            gap = 0;
            tx_calm = $urandom_range(50, 150);
        end
        else
            gap = idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic tx_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (due_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cap(input logic [16:0] v);
        wait_drained();
        repeat (150) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One packet: mostly well formed, some rejected on the first byte, some cut short.
    task automatic send_packet();
        logic [7:0]  pkt [$];
        logic [3:0]  ver;
        logic [15:0] beat_len;
        logic [15:0] field;
        int          kind;
        int          ihl;
        int          hl;
        int          pay;
        int          plen_decl;
        int          cut;
        bit          v6;
        bit          noisy;
        kind  = $urandom_range(0, 99);
        noisy = ($urandom_range(0, 9) == 0);
        cut   = -1;
        ihl   = 5;
        if (kind >= 80 && kind < 90)
        begin
            ihl = $urandom_range(0, 15);
            case ($urandom_range(0, 3))
                0:
                begin
                    do
                        ver = 4'($urandom);
                    while (ver == VER_V4 || ver == VER_V6);
                    plen_decl = $urandom_range(1, 24);
                end
                1:
                begin
                    ver = VER_V4;
                    plen_decl = $urandom_range(1, 19);
                end
                2:
                begin
                    ver = VER_V4;
                    ihl = $urandom_range(0, 4);
                    plen_decl = $urandom_range(20, 30);
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        ver = VER_V4;
                        ihl = $urandom_range(6, 15);
                        plen_decl = $urandom_range(20, ihl * 4 - 1);
                    end
                    else
                    begin
                        ver = VER_V6;
                        plen_decl = $urandom_range(1, 39);
                    end
                end
            endcase
            for (int i = 0; i < plen_decl; i++)
                pkt.push_back(8'($urandom));
            pkt[0] = {ver, 4'(ihl)};
        end
        else
        begin
            v6  = (kind >= 55 && kind < 80) || (kind >= 90 && $urandom_range(0, 1) == 1);
            pay = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            if (v6)
                hl = V6_HLEN;
            else
            begin
                ihl = ($urandom_range(0, 2) == 0) ? $urandom_range(6, 15) : 5;
                hl  = ihl * 4;
            end
            plen_decl = hl + pay;
            for (int i = 0; i < plen_decl; i++)
                pkt.push_back(8'($urandom));
            if (v6)
            begin
                pkt[0] = {VER_V6, 4'($urandom)};
                case ($urandom_range(0, 9))
                    0:       field = 16'(pay + $urandom_range(1, 200));
                    1:       field = 16'($urandom_range(0, pay));
                    default: field = 16'(pay);
                endcase
                pkt[IDX_V6_PLEN_HI] = field[15:8];
                pkt[IDX_V6_PLEN_LO] = field[7:0];
                pkt[IDX_V6_HOP] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1))
                                                              : 8'($urandom_range(2, 255));
            end
            else
            begin
                pkt[0] = {VER_V4, 4'(ihl)};
                case ($urandom_range(0, 9))
                    0:       field = 16'(plen_decl + $urandom_range(1, 200));
                    1:       field = 16'($urandom_range(0, plen_decl));
                    default: field = 16'(plen_decl);
                endcase
                pkt[IDX_V4_TLEN_HI] = field[15:8];
                pkt[IDX_V4_TLEN_LO] = field[7:0];
                pkt[IDX_V4_TTL] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1))
                                                              : 8'($urandom_range(2, 255));
            end
            if (kind >= 90)
            begin
                cut = $urandom_range(1, plen_decl);
                plen_decl = ($urandom_range(0, 3) == 0) ? 65535
                                                        : $urandom_range(plen_decl + 1, 65535);
            end
        end
        for (int i = 0; i < pkt.size(); i++)
        begin
            if (i == cut)
                break;
            beat_len = 16'(plen_decl);
            if (i > 0 && noisy && $urandom_range(0, 2) == 0)
                beat_len = 16'($urandom_range(1, 65535));
            send_beat(pkt[i], beat_len, 1'b0, ST_OK);
        end
        if (cut >= 0)
            send_beat(8'($urandom), 16'd0, 1'b0, ST_OK);
    endtask

    // output side back-pressure
    initial
    begin
        int stall;
        int calm;
        stall = 0;
        calm  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (399) @(negedge clk);
            end
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (calm > 0)
                    calm--;
                else if ($urandom_range(0, 99) == 0)
                    calm = $urandom_range(100, 300);
                else
                    stall = idle_len();
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [16:0] caps [6];
        int          target;
        model_count = 16'd0;
        model_plen  = 16'd0;
        model_hlen  = 0;
        model_phase = PH_COLLECT;
        model_cap   = MAX_OUT_RST;
        caps[0] = MAX_OUT_RST;
        caps[1] = 17'h00000;
        caps[2] = 17'h0FFFF;
        caps[3] = 17'($urandom_range(30, 90));
        caps[4] = 17'($urandom_range(30, 90));
        caps[5] = MAX_OUT_RST;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (PROBES[i])
            send_beat(PROBES[i].d, PROBES[i].len, PROBES[i].typed, PROBES[i].st);

        for (int p = 0; p < 6; p++)
        begin
            tx_idle();
            write_cap(caps[p]);
            if (p == 2)
                hold_req = 1'b1;
            target = sent_items + 32;
            while (sent_items < target)
            begin
                send_packet();
                if ($urandom_range(0, 19) == 0)
                begin
                    tx_idle();
                    wait_drained();
                end
            end
        end

        tx_idle();
        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && due_beats.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### ip_ttl_decrement_encapsulate.f
design/ittl_pkg.sv
design/ittl_queue.sv
design/ittl_front.sv
design/ittl_back.sv
design/ip_ttl_decrement_encapsulate.sv
tb/tb_top.sv
